FILE: sv/sbe_pkg.sv
// shared types and constants of the stack bytecode executor
// no dependencies; imported by every module of the block but sbe_ram
`default_nettype none

package sbe_pkg;

  localparam int STACK_ENTRIES = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int WORD_W        = 32;
  localparam int IMM_W         = 8;
  localparam int MODE_W        = 4;
  localparam int HEIGHT_W      = $clog2(STACK_ENTRIES + 1);
  localparam int ADDR_W        = $clog2(STACK_ENTRIES);
  localparam int DUMP_CNT_W    = $clog2(MAX_RESULTS);
  localparam int DIV_CNT_W     = $clog2(WORD_W);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH     = 4'd0,
    MODE_ADD      = 4'd1,
    MODE_SUB      = 4'd2,
    MODE_MUL      = 4'd3,
    MODE_DIV      = 4'd4,
    MODE_INT_RET  = 4'd5,
    MODE_VOID_RET = 4'd6,
    MODE_DUMP     = 4'd7
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DUMP  = 2'd0,
    KIND_INT   = 2'd1,
    KIND_VOID  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_UNDERFLOW = 3'd1,
    STATUS_OVERFLOW  = 3'd2,
    STATUS_DIV_ZERO  = 3'd3,
    STATUS_INVALID   = 3'd4,
    STATUS_MISMATCH  = 3'd5,
    STATUS_NO_RETURN = 3'd6
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [IMM_W-1:0] immediate;
    logic                    end_of_code;
  } instr_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [WORD_W-1:0] value;
    status_t                  status;
    logic                     last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_A,
    ST_RD_B,
    ST_EXEC,
    ST_DIV,
    ST_DIV_END,
    ST_WRITE,
    ST_EMIT,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic addr_next;
    logic push_write;
    logic arith_write;
    logic a_load;
    logic b_load;
    logic pend_load;
    logic pend_div0;
    logic res_load;
    logic res_div;
    logic div_start;
    logic div_step;
    logic out_load;
    logic out_dump;
    logic dump_pop;
    logic frame_close;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              dec_err;
    logic              stack_empty;
    logic              a_zero;
    logic              div_last;
    logic              out_free;
    logic              dump_last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/sbe_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/sbe_ctrl.sv
// sequencer of the stack bytecode executor: one instruction at a time
// depends on sbe_pkg; drives the datapath command struct
`default_nettype none

module sbe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  sbe_pkg::dp_status_t status,
  output sbe_pkg::dp_cmd_t   cmd,
  output logic               busy
);
  import sbe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.pend_load = 1'b1;
        if (status.dec_err) begin
          state_next = ST_EMIT;
        end else begin
          unique case (status.mode)
            MODE_PUSH: begin
              cmd.push_write = 1'b1;
              state_next     = ST_IDLE;
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_INT_RET: begin
              state_next = ST_RD_A;
            end
            MODE_VOID_RET: begin
              state_next = ST_EMIT;
            end
            MODE_DUMP: begin
              state_next = status.stack_empty ? ST_IDLE : ST_DUMP;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD_A: begin
        cmd.a_load = 1'b1;
        if (status.mode == MODE_INT_RET) begin
          state_next = ST_EMIT;
        end else begin
          cmd.addr_next = 1'b1;
          state_next    = ST_RD_B;
        end
      end
      ST_RD_B: begin
        cmd.b_load = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.mode == MODE_DIV) begin
          if (status.a_zero) begin
            cmd.pend_div0 = 1'b1;
            state_next    = ST_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
        end else begin
          cmd.res_load = 1'b1;
          state_next   = ST_WRITE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd.res_load = 1'b1;
        cmd.res_div  = 1'b1;
        state_next   = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.arith_write = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.frame_close = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_DUMP: begin
        // read the next entry in the same cycle that the current one leaves
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_dump  = 1'b1;
          cmd.dump_pop  = 1'b1;
          cmd.addr_next = 1'b1;
          if (status.dump_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/sbe_dp.sv
// datapath: stack memory, height and frame registers, alu, serial divider
// and the result register; depends on sbe_pkg and sbe_ram
`default_nettype none

module sbe_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  sbe_pkg::instr_t     instr,
  input  sbe_pkg::dp_cmd_t    cmd,
  output sbe_pkg::dp_status_t status,
  output logic                result_valid,
  input  logic                result_stall,
  output sbe_pkg::result_t    result
);
  import sbe_pkg::*;

  instr_t              item;
  logic [HEIGHT_W-1:0] height;
  logic [HEIGHT_W-1:0] frame_base;
  logic                frame_open;

  logic [WORD_W-1:0]   a_reg;
  logic [WORD_W-1:0]   b_reg;
  logic [WORD_W-1:0]   res_reg;
  logic [WORD_W-1:0]   alu_out;
  logic [WORD_W-1:0]   imm_ext;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic [WORD_W-1:0]   rd_data;
  logic [ADDR_W-1:0]   top_addr;
  logic [ADDR_W-1:0]   next_addr;

  logic                dec_err;
  kind_t               dec_kind;
  status_t             dec_status;
  kind_t               pend_kind;
  status_t             pend_status;

  logic [DUMP_CNT_W-1:0] dump_cnt;

  logic [WORD_W-1:0]   div_rem;
  logic [WORD_W-1:0]   div_quo;
  logic [WORD_W-1:0]   div_den;
  logic                div_neg;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [WORD_W:0]     div_shift;
  logic [WORD_W:0]     div_diff;
  logic [WORD_W-1:0]   a_mag;
  logic [WORD_W-1:0]   b_mag;
  logic [WORD_W-1:0]   div_result;

  logic                out_free;

  // stack memory
  sbe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_ENTRIES)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign top_addr  = ADDR_W'(height - HEIGHT_W'(1));
  assign next_addr = ADDR_W'(height - HEIGHT_W'(2));
  assign rd_addr   = cmd.addr_next ? next_addr : top_addr;
  assign imm_ext   = {{(WORD_W - IMM_W){item.immediate[IMM_W-1]}}, item.immediate};
  assign wr_en     = cmd.push_write | cmd.arith_write;
  assign wr_addr   = cmd.push_write ? height[ADDR_W-1:0] : next_addr;
  assign wr_data   = cmd.push_write ? imm_ext : res_reg;

  // checks, in the order they take precedence
  always_comb begin
    dec_err    = 1'b1;
    dec_kind   = KIND_ERROR;
    dec_status = STATUS_OK;
    priority if (item.mode > MODE_DUMP) begin
      dec_status = STATUS_INVALID;
    end else if (item.end_of_code && item.mode != MODE_INT_RET
                 && item.mode != MODE_VOID_RET) begin
      dec_status = STATUS_NO_RETURN;
    end else if (item.mode == MODE_PUSH && height >= HEIGHT_W'(STACK_ENTRIES)) begin
      dec_status = STATUS_OVERFLOW;
    end else if (item.mode >= MODE_ADD && item.mode <= MODE_DIV
                 && height < HEIGHT_W'(2)) begin
      dec_status = STATUS_UNDERFLOW;
    end else if (item.mode == MODE_INT_RET && height == '0) begin
      dec_status = STATUS_UNDERFLOW;
    end else if (item.mode == MODE_INT_RET
                 && {1'b0, height} != {1'b0, frame_base} + (HEIGHT_W + 1)'(1)) begin
      dec_status = STATUS_MISMATCH;
    end else if (item.mode == MODE_VOID_RET && height != frame_base) begin
      dec_status = STATUS_MISMATCH;
    end else begin
      dec_err  = 1'b0;
      dec_kind = (item.mode == MODE_INT_RET) ? KIND_INT : KIND_VOID;
    end
  end

  always_comb begin
    priority if (item.mode == MODE_ADD) begin
      alu_out = b_reg + a_reg;
    end else if (item.mode == MODE_SUB) begin
      alu_out = b_reg - a_reg;
    end else begin
      alu_out = b_reg * a_reg;
    end
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  assign a_mag      = a_reg[WORD_W-1] ? (WORD_W'(0) - a_reg) : a_reg;
  assign b_mag      = b_reg[WORD_W-1] ? (WORD_W'(0) - b_reg) : b_reg;
  assign div_shift  = {div_rem, div_quo[WORD_W-1]};
  assign div_diff   = div_shift - {1'b0, div_den};
  assign div_result = div_neg ? (WORD_W'(0) - div_quo) : div_quo;

  assign out_free = !result_valid || !result_stall;

  assign status.mode        = item.mode;
  assign status.dec_err     = dec_err;
  assign status.stack_empty = (height == '0);
  assign status.a_zero      = (a_reg == '0);
  assign status.div_last    = (div_cnt == DIV_CNT_W'(WORD_W - 1));
  assign status.out_free    = out_free;
  assign status.dump_last   = (height == HEIGHT_W'(1))
                              || (dump_cnt == DUMP_CNT_W'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      height       <= '0;
      frame_base   <= '0;
      frame_open   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept && !frame_open) begin
        frame_open <= 1'b1;
        frame_base <= height;
      end else if (cmd.frame_close) begin
        frame_open <= 1'b0;
      end
      if (cmd.push_write) begin
        height <= height + HEIGHT_W'(1);
      end else if (cmd.arith_write || cmd.dump_pop) begin
        height <= height - HEIGHT_W'(1);
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= instr;
      dump_cnt <= '0;
    end else if (cmd.dump_pop) begin
      dump_cnt <= dump_cnt + DUMP_CNT_W'(1);
    end
    if (cmd.a_load) begin
      a_reg <= rd_data;
    end
    if (cmd.b_load) begin
      b_reg <= rd_data;
    end
    if (cmd.pend_load) begin
      pend_kind   <= dec_kind;
      pend_status <= dec_status;
    end else if (cmd.pend_div0) begin
      pend_kind   <= KIND_ERROR;
      pend_status <= STATUS_DIV_ZERO;
    end
    if (cmd.res_load) begin
      res_reg <= cmd.res_div ? div_result : alu_out;
    end
    if (cmd.div_start) begin
      div_rem <= '0;
      div_quo <= b_mag;
      div_den <= a_mag;
      div_neg <= a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!div_diff[WORD_W]) begin
        div_rem <= div_diff[WORD_W-1:0];
        div_quo <= {div_quo[WORD_W-2:0], 1'b1};
      end else begin
        div_rem <= div_shift[WORD_W-1:0];
        div_quo <= {div_quo[WORD_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.out_load) begin
      if (cmd.out_dump) begin
        result.kind   <= KIND_DUMP;
        result.value  <= $signed(rd_data);
        result.status <= STATUS_OK;
        result.last   <= status.dump_last;
      end else begin
        result.kind   <= pend_kind;
        result.value  <= (pend_kind == KIND_INT) ? $signed(a_reg) : '0;
        result.status <= pend_status;
        result.last   <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/stack_bytecode_executor.sv
// top level of the stack bytecode executor: joins sequencer and datapath
// depends on sbe_pkg, sbe_ctrl, sbe_dp (and sbe_ram below it)
//
// usage: one instruction per transfer on the instr channel, results on the
// result channel, both valid/stall. The block works on one instruction at a
// time and stalls instr until the current one is finished.
// each instruction is decoded first; push then writes the stack, add/sub/mul
// read both operands, compute and write back, div runs the 32-step serial
// divider instead of the compute, int return reads and emits the top, void
// return and decode errors emit at once, divide by zero after the operands.
// a result is registered in the output register before it is shown; while
// result_stall is high on a shown result the register holds and the sequencer
// waits in front of it, so a dump pops one entry per free output slot.
// every instruction that gives results sets last on its final one; push and the
// arithmetic ops give no result unless they fail, nor does dump on an empty stack.
// reset (rst, synchronous) empties the stack and clears the frame; the
// block takes an instruction in the first cycle after reset.
`default_nettype none

module stack_bytecode_executor (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_stall,
  input  sbe_pkg::instr_t  instr,
  output logic             result_valid,
  input  logic             result_stall,
  output sbe_pkg::result_t result
);
  import sbe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       busy;
  logic       accept;

  assign instr_stall = busy;
  assign accept      = instr_valid && !busy;

  sbe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sbe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .instr        (instr),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> instr_stall)
    else $error("block did not go busy after taking an instruction");

  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_DUMP |-> result.last)
    else $error("return or error report without last");

  a_error_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.kind == KIND_ERROR) == (result.status != STATUS_OK)))
    else $error("status does not match result kind");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
// testbench of the stack bytecode executor: a directed table, then random functions
// depends on sbe_pkg and stack_bytecode_executor; results are checked against a shadow stack
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbe_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int PRINT_CAP     = 100;
  localparam int DIRECTED_ROWS = 26;
  localparam int PHASE_ITEMS   = 95;
  localparam int HOLD_ITEMS    = 30;
  localparam logic [MODE_W-1:0] MODE_BAD_LO = 4'd8;
  localparam logic [MODE_W-1:0] MODE_BAD_HI = 4'd15;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IMM_W-1:0]  imm;
    logic              eoc;
    logic [4:0]        rep;
    logic              typed;
    kind_t             kind;
    logic [WORD_W-1:0] value;
    status_t           status;
  } stim_row_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    instr_valid = 1'b0;
  logic    instr_stall;
  instr_t  instr = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;

  // shadow copy of the block state
  logic [WORD_W-1:0] shadow_stack [STACK_ENTRIES];
  int unsigned       stack_depth  = 0;
  int unsigned       frame_floor  = 0;
  bit                frame_active = 1'b0;

  result_t step_results [MAX_RESULTS];
  int      step_count;
  result_t expected_results [$];

  // rows with a typed result carry exactly one result with last set
  stim_row_t dir_rows [DIRECTED_ROWS] = '{
    '{MODE_INT_RET,  8'h00, 1'b0, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_UNDERFLOW},
    '{MODE_BAD_HI,   8'h55, 1'b1, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_INVALID},
    '{MODE_BAD_LO,   8'haa, 1'b0, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_INVALID},
    '{MODE_ADD,      8'h00, 1'b0, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_UNDERFLOW},
    '{MODE_VOID_RET, 8'hff, 1'b1, 5'd1,  1'b1, KIND_VOID,  32'h0, STATUS_OK},
    '{MODE_DUMP,     8'h00, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_PUSH,     8'h7f, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_PUSH,     8'h80, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_MUL,      8'h00, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_PUSH,     8'h00, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_DIV,      8'h00, 1'b0, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_DIV_ZERO},
    '{MODE_PUSH,     8'h05, 1'b1, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_NO_RETURN},
    '{MODE_SUB,      8'h00, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_INT_RET,  8'h00, 1'b1, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_MISMATCH},
    '{MODE_PUSH,     8'h80, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_PUSH,     8'h40, 1'b0, 5'd4,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_MUL,      8'h00, 1'b0, 5'd4,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_PUSH,     8'hff, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_DIV,      8'h00, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_INT_RET,  8'h00, 1'b0, 5'd1,  1'b1, KIND_INT,   32'h8000_0000, STATUS_OK},
    '{MODE_PUSH,     8'h01, 1'b0, 5'd14, 1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_PUSH,     8'h03, 1'b0, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_OVERFLOW},
    '{MODE_DUMP,     8'h00, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_VOID_RET, 8'h00, 1'b1, 5'd1,  1'b1, KIND_ERROR, 32'h0, STATUS_MISMATCH},
    '{MODE_PUSH,     8'h07, 1'b0, 5'd1,  1'b0, KIND_DUMP,  32'h0, STATUS_OK},
    '{MODE_INT_RET,  8'h00, 1'b1, 5'd1,  1'b1, KIND_INT,   32'd7, STATUS_OK}
  };

  stack_bytecode_executor i_dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("stack_bytecode_executor regression: fail");
    $finish;
  end

  task automatic report_mismatch(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at %0t: %s is %0h, want %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // appends one result to the scoreboard queue
  function automatic void expect_result(result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void queue_step_result(kind_t kind, logic [WORD_W-1:0] value,
                                            status_t status, logic last);
    step_results[DUMP_CNT_W'(step_count)] = '{kind: kind, value: value, status: status,
                                              last: last};
    step_count++;
  endfunction

  // any error leaves the stack alone and ends the function
  function automatic void raise_error(status_t status);
    frame_active = 1'b0;
    queue_step_result(KIND_ERROR, '0, status, 1'b1);
  endfunction

  function automatic logic [WORD_W-1:0] quotient_trunc(logic [WORD_W-1:0] b, logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] mag_b;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] q;
    mag_b = b[WORD_W-1] ? -b : b;
    mag_a = a[WORD_W-1] ? -a : a;
    q = mag_b / mag_a;
    return (b[WORD_W-1] != a[WORD_W-1]) ? -q : q;
  endfunction

  function automatic void execute_instr(instr_t it);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] r;
    int unsigned       n;
    step_count = 0;
    if (!frame_active) begin
      frame_active = 1'b1;
      frame_floor = stack_depth;
    end
    if (it.mode > MODE_DUMP) begin
      raise_error(STATUS_INVALID);
    end else if (it.end_of_code && it.mode != MODE_INT_RET && it.mode != MODE_VOID_RET) begin
      raise_error(STATUS_NO_RETURN);
    end else begin
      case (it.mode)
        MODE_PUSH: begin
          if (stack_depth >= STACK_ENTRIES) begin
            raise_error(STATUS_OVERFLOW);
          end else begin
            shadow_stack[ADDR_W'(stack_depth)] =
              {{(WORD_W-IMM_W){it.immediate[IMM_W-1]}}, it.immediate};
            stack_depth++;
          end
        end
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
          if (stack_depth < 2) begin
            raise_error(STATUS_UNDERFLOW);
          end else begin
            a = shadow_stack[ADDR_W'(stack_depth-1)];
            b = shadow_stack[ADDR_W'(stack_depth-2)];
            if (it.mode == MODE_DIV && a == '0) begin
              raise_error(STATUS_DIV_ZERO);
            end else begin
              case (it.mode)
                MODE_ADD: r = b + a;
                MODE_SUB: r = b - a;
                MODE_MUL: r = b * a;
                default:  r = quotient_trunc(b, a);
              endcase
              stack_depth--;
              shadow_stack[ADDR_W'(stack_depth-1)] = r;
            end
          end
        end
        MODE_INT_RET: begin
          if (stack_depth == 0) begin
            raise_error(STATUS_UNDERFLOW);
          end else if (stack_depth != frame_floor + 1) begin
            raise_error(STATUS_MISMATCH);
          end else begin
            frame_active = 1'b0;
            queue_step_result(KIND_INT, shadow_stack[ADDR_W'(stack_depth-1)], STATUS_OK, 1'b1);
          end
        end
        MODE_VOID_RET: begin
          if (stack_depth != frame_floor) begin
            raise_error(STATUS_MISMATCH);
          end else begin
            frame_active = 1'b0;
            queue_step_result(KIND_VOID, '0, STATUS_OK, 1'b1);
          end
        end
        default: begin
          // dump pops top first, at most one full burst, may dig below the frame
          n = (stack_depth < MAX_RESULTS) ? stack_depth : MAX_RESULTS;
          for (int i = 0; i < n; i++) begin
            stack_depth--;
            queue_step_result(KIND_DUMP, shadow_stack[ADDR_W'(stack_depth)], STATUS_OK,
                              i == n - 1);
          end
        end
      endcase
    end
  endfunction

  function automatic instr_t make_instr(logic [MODE_W-1:0] mode, logic [IMM_W-1:0] imm, logic eoc);
    instr_t it;
    it.mode = mode;
    it.immediate = imm;
    it.end_of_code = eoc;
    return it;
  endfunction

  // holds the payload until the transfer; valid stays up for a back-to-back item
  task automatic drive_instr(instr_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      instr_valid <= 1'b0;
      @(posedge clk);
    end
    instr <= it;
    instr_valid <= 1'b1;
    @(posedge clk);
    while (instr_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_predicted(instr_t it);
    execute_instr(it);
    for (int i = 0; i < step_count; i++) expect_result(step_results[DUMP_CNT_W'(i)]);
    drive_instr(it);
  endtask

  task automatic wait_results_done();
    instr_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_arith();
    logic [MODE_W-1:0] op;
    op = MODE_W'($urandom_range(int'(MODE_DIV), int'(MODE_ADD)));
    if (op == MODE_DIV && shadow_stack[ADDR_W'(stack_depth-1)] == '0) op = MODE_ADD;
    send_predicted(make_instr(op, IMM_W'($urandom), 1'b0));
  endtask

  task automatic random_noise();
    int burst;
    burst = $urandom_range(4, 1);
    repeat (burst)
      send_predicted(make_instr(MODE_W'($urandom_range(15)), IMM_W'($urandom),
                                $urandom_range(3) == 0));
  endtask

  // if no frame is open, the dump opens one at the old height, so the void return after it misses
  task automatic drain_stack();
    send_predicted(make_instr(MODE_DUMP, IMM_W'($urandom), 1'b0));
    send_predicted(make_instr(MODE_VOID_RET, IMM_W'($urandom), 1'b1));
  endtask

  task automatic random_function();
    int unsigned base;
    int          body;
    if (frame_active) send_predicted(make_instr(MODE_VOID_RET, IMM_W'($urandom), 1'b1));
    base = stack_depth;
    if ($urandom_range(4) == 0) begin
      send_predicted(make_instr(MODE_VOID_RET, IMM_W'($urandom), 1'b1));
    end else begin
      body = $urandom_range(8, 1);
      repeat (body) begin
        if (stack_depth < base + 2 || (stack_depth < STACK_ENTRIES - 1 && $urandom_range(1) == 0))
          send_predicted(make_instr(MODE_PUSH, IMM_W'($urandom), 1'b0));
        else
          send_arith();
      end
      while (stack_depth > base + 1) send_arith();
      // now and then return early, the next item opens a new function
      send_predicted(make_instr(MODE_INT_RET, IMM_W'($urandom), $urandom_range(4) != 0));
    end
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if (stack_depth >= 12 && $urandom_range(3) != 0)
        drain_stack();
      else if ($urandom_range(3) == 0)
        random_noise();
      else
        random_function();
    end
  endtask

  initial begin : result_monitor
    result_t want;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, value", result.value, '0);
        end else begin
          want = expected_results.pop_front();
          if (result.kind !== want.kind)
            report_mismatch("kind", WORD_W'(result.kind), WORD_W'(want.kind));
          if (result.value !== want.value) report_mismatch("value", result.value, want.value);
          if (result.status !== want.status)
            report_mismatch("status", WORD_W'(result.status), WORD_W'(want.status));
          if (result.last !== want.last)
            report_mismatch("last", WORD_W'(result.last), WORD_W'(want.last));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    instr_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      for (int k = 0; k < dir_rows[r].rep; k++) begin
        it = make_instr(dir_rows[r].mode, dir_rows[r].imm, dir_rows[r].eoc);
        if (dir_rows[r].typed) begin
          execute_instr(it);
          expect_result(result_t'{kind: dir_rows[r].kind, value: dir_rows[r].value,
                                  status: dir_rows[r].status, last: 1'b1});
          drive_instr(it);
        end else begin
          send_predicted(it);
        end
      end
    end
    wait_results_done();

    run_random(PHASE_ITEMS);
    wait_results_done();
    tx_idle_pct = 77;
    run_random(PHASE_ITEMS);
    wait_results_done();
    tx_idle_pct = 0;
    rx_stall_pct = 77;
    run_random(PHASE_ITEMS);
    wait_results_done();
    tx_idle_pct = 32;
    rx_stall_pct = 32;
    run_random(PHASE_ITEMS);
    wait_results_done();

    // receiver holds off while the sender keeps offering, so the block backs up
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b1;
    run_random(HOLD_ITEMS);
    wait_results_done();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never seen, count", WORD_W'(expected_results.size()), '0);
    if (mismatch_count == 0)
      $display("stack_bytecode_executor regression: pass");
    else
      $display("stack_bytecode_executor regression: fail");
    $finish;
  end

endmodule
